[hdl/krla_pkg.sv]
// Shared types, constants and helper functions for the keypad ripple LED animator.
package krla_pkg;

  localparam int MAX_SLOTS_DEF = 4;
  localparam int NUM_PIXELS    = 12;
  localparam int NUM_KEYS      = 12;
  localparam int NUM_FRAMES    = 6;

  localparam int KEY_W    = 4;
  localparam int PIXEL_W  = 4;
  localparam int FRAME_W  = 3;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int LEVEL_W  = 8;

  localparam logic [LEVEL_W-1:0] RESET_BRIGHTNESS = 8'd80;
  localparam logic [FRAME_W-1:0] LAST_FRAME       = FRAME_W'(NUM_FRAMES - 1);
  localparam logic [FRAME_W-1:0] FIRST_FRAME      = '0;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                command;
    logic [KEY_W-1:0]    key;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic                inward;
  } item_t;

  typedef struct packed {
    logic                phase;
    logic [PIXEL_W-1:0]  pixel;
    logic [CHAN_W-1:0]   out_red;
    logic [CHAN_W-1:0]   out_green;
    logic [CHAN_W-1:0]   out_blue;
    logic [LEVEL_W-1:0]  level;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                is_tick;
    logic [KEY_W-1:0]    key;
    logic [COLOUR_W-1:0] colour;
    logic                inward;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } qhead_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_EMIT,
    B_COMPACT
  } back_state_t;

  // Row of a key or pixel on the 3-wide grid
  function automatic logic [1:0] row_of(input logic [3:0] v);
    logic [1:0] r;
    if (v >= 4'd9)      r = 2'd3;
    else if (v >= 4'd6) r = 2'd2;
    else if (v >= 4'd3) r = 2'd1;
    else                r = 2'd0;
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] v);
    logic [1:0] r;
    logic [3:0] base;
    r    = row_of(v);
    base = {1'b0, r, 1'b0} + {2'b00, r};
    return 2'(v - base);
  endfunction

  // Manhattan distance between key and pixel, 0..5
  function automatic logic [FRAME_W-1:0] ring_dist(input logic [3:0] k, input logic [3:0] p);
    logic [1:0] kr, kc, pr, pc, dr, dc;
    kr = row_of(k);
    kc = col_of(k);
    pr = row_of(p);
    pc = col_of(p);
    dr = (kr > pr) ? 2'(kr - pr) : 2'(pr - kr);
    dc = (kc > pc) ? 2'(kc - pc) : 2'(pc - kc);
    return FRAME_W'(dr) + FRAME_W'(dc);
  endfunction

endpackage

[hdl/keypad_ripple_led_animator.sv]
// Top level of the keypad ripple LED animator.
//
// Drives ripple animations on a 12-LED keypad (3 columns by 4 rows).
// A command is taken when start is high and busy is low. A start command
// opens a ripple slot (or reverses an outward ripple on the same key when
// the new start is inward); starts on keys past the key count, or while
// every slot is in use, are dropped. A tick command produces 24 results:
// the main frame (phase 0) then the overlap frame (phase 1), pixels 0..11
// in order, with last set on the final one. Each result is on the result
// port for exactly one cycle, flagged by result_valid, and the receiver
// cannot stall it: it must take every transfer as it comes.
// Commands pass through a 2-entry queue into the executing back end. On
// a tick the back end emits one pixel per cycle and then ages and compacts
// the slot table one slot per cycle. Each result is registered and appears
// in the cycle after its pixel is computed. busy is high only while the
// queue is full, so the host may hand over the next command while a tick
// is still streaming. brightness is passed through as level on each result;
// write it only while the block is idle.
module keypad_ripple_led_animator #(
  parameter int MAX_SLOTS = krla_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  krla_pkg::item_t               item,
  output logic                          busy,
  input  logic                          brightness_we,
  input  logic [krla_pkg::LEVEL_W-1:0]  brightness_wdata,
  output logic                          result_valid,
  output krla_pkg::result_t             result
);

  // Queue head to back end, pop back to the queue
  krla_pkg::qhead_t head;
  logic             pop;

  krla_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .pop   (pop),
    .head  (head)
  );

  krla_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .brightness_we    (brightness_we),
    .brightness_wdata (brightness_wdata),
    .result_valid     (result_valid),
    .result           (result)
  );

endmodule

[hdl/krla_front.sv]
// Front end: accepts commands, drops out-of-range starts, and queues the rest.
module krla_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  krla_pkg::item_t   item,
  output logic              busy,
  input  logic              pop,
  output krla_pkg::qhead_t  head
);

  krla_pkg::qentry_t                 fifo [krla_pkg::QUEUE_DEPTH];
  logic [krla_pkg::QIDX_W-1:0]       wr_ptr;
  logic [krla_pkg::QIDX_W-1:0]       rd_ptr;
  logic [krla_pkg::QCNT_W-1:0]       count;
  logic                              accept;
  logic                              keep;
  logic                              push;
  krla_pkg::qentry_t                 entry_in;

  assign busy   = (count == krla_pkg::QCNT_W'(krla_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;
  assign keep   = (item.command == krla_pkg::CMD_TICK) ||
                  (item.key < krla_pkg::KEY_W'(krla_pkg::NUM_KEYS));
  assign push   = accept && keep;

  always_comb begin
    entry_in.is_tick = (item.command == krla_pkg::CMD_TICK);
    entry_in.key     = item.key;
    entry_in.colour  = {item.red, item.green, item.blue};
    entry_in.inward  = item.inward;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == krla_pkg::QIDX_W'(krla_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == krla_pkg::QIDX_W'(krla_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.entry = fifo[rd_ptr];

endmodule

[hdl/krla_back.sv]
// Back end: ripple slot table, frame emission and slot aging/compaction.
module krla_back #(
  parameter int MAX_SLOTS = krla_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  krla_pkg::qhead_t              head,
  output logic                          pop,
  input  logic                          brightness_we,
  input  logic [krla_pkg::LEVEL_W-1:0]  brightness_wdata,
  output logic                          result_valid,
  output krla_pkg::result_t             result
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  krla_pkg::back_state_t state, state_next;
  krla_pkg::qentry_t     cur;

  logic [krla_pkg::KEY_W-1:0]    slot_key    [MAX_SLOTS];
  logic [krla_pkg::FRAME_W-1:0]  slot_frame  [MAX_SLOTS];
  logic                          slot_inward [MAX_SLOTS];
  logic [krla_pkg::COLOUR_W-1:0] slot_colour [MAX_SLOTS];
  logic [CNT_W-1:0]              active_count;

  logic                          phase;
  logic [krla_pkg::PIXEL_W-1:0]  pixel;
  logic [CNT_W-1:0]              scan;
  logic [CNT_W-1:0]              fill;
  logic [krla_pkg::LEVEL_W-1:0]  brightness;

  logic                          frame_done;
  logic                          full;
  logic                          found;
  logic [IDX_W-1:0]              found_idx;
  logic [krla_pkg::COLOUR_W-1:0] pix_colour;
  logic                          result_valid_next;
  krla_pkg::result_t             result_next;
  logic [IDX_W-1:0]              scan_idx;
  logic [IDX_W-1:0]              fill_idx;
  logic [IDX_W-1:0]              new_idx;
  logic                          scan_final;

  assign frame_done = phase && (pixel == krla_pkg::PIXEL_W'(krla_pkg::NUM_PIXELS - 1));
  assign full       = (active_count == CNT_W'(MAX_SLOTS));
  assign scan_idx   = scan[IDX_W-1:0];
  assign fill_idx   = fill[IDX_W-1:0];
  assign new_idx    = active_count[IDX_W-1:0];
  assign scan_final = slot_inward[scan_idx] ? (slot_frame[scan_idx] == krla_pkg::FIRST_FRAME)
                                            : (slot_frame[scan_idx] == krla_pkg::LAST_FRAME);

  // Lowest active outward slot on the start key
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!found && (CNT_W'(i) < active_count) && (slot_key[i] == cur.key) &&
          !slot_inward[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // Colour of the current pixel; later slots override earlier ones
  always_comb begin
    logic [krla_pkg::FRAME_W-1:0] d;
    logic [krla_pkg::FRAME_W-1:0] nf;
    logic                         fin;
    logic                         hit;
    pix_colour = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      d   = krla_pkg::ring_dist(slot_key[i], pixel);
      fin = slot_inward[i] ? (slot_frame[i] == krla_pkg::FIRST_FRAME)
                           : (slot_frame[i] == krla_pkg::LAST_FRAME);
      nf  = slot_inward[i] ? slot_frame[i] - 1'b1 : slot_frame[i] + 1'b1;
      hit = (d == slot_frame[i]) || (phase && !fin && (d == nf));
      if ((CNT_W'(i) < active_count) && hit) begin
        pix_colour = slot_colour[i];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      krla_pkg::B_IDLE: begin
        if (head.valid) begin
          state_next = head.entry.is_tick ? krla_pkg::B_EMIT : krla_pkg::B_START;
        end
      end
      krla_pkg::B_START: begin
        state_next = krla_pkg::B_IDLE;
      end
      krla_pkg::B_EMIT: begin
        if (frame_done) begin
          state_next = krla_pkg::B_COMPACT;
        end
      end
      krla_pkg::B_COMPACT: begin
        if (scan == active_count) begin
          state_next = krla_pkg::B_IDLE;
        end
      end
      default: state_next = krla_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop                   = (state == krla_pkg::B_IDLE) && head.valid;
    result_valid_next     = (state == krla_pkg::B_EMIT);
    result_next.phase     = phase;
    result_next.pixel     = pixel;
    result_next.out_red   = pix_colour[23:16];
    result_next.out_green = pix_colour[15:8];
    result_next.out_blue  = pix_colour[7:0];
    result_next.level     = brightness;
    result_next.last      = frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= krla_pkg::B_IDLE;
      active_count <= '0;
      brightness   <= krla_pkg::RESET_BRIGHTNESS;
      result_valid <= 1'b0;
      phase        <= 1'b0;
      pixel        <= '0;
      scan         <= '0;
      fill         <= '0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (brightness_we) begin
        brightness <= brightness_wdata;
      end
      unique case (state)
        krla_pkg::B_IDLE: begin
          phase <= 1'b0;
          pixel <= '0;
          scan  <= '0;
          fill  <= '0;
        end
        krla_pkg::B_START: begin
          if (!full && !(cur.inward && found)) begin
            active_count <= active_count + 1'b1;
          end
        end
        krla_pkg::B_EMIT: begin
          if (pixel == krla_pkg::PIXEL_W'(krla_pkg::NUM_PIXELS - 1)) begin
            pixel <= '0;
            phase <= 1'b1;
          end else begin
            pixel <= pixel + 1'b1;
          end
        end
        krla_pkg::B_COMPACT: begin
          if (scan == active_count) begin
            active_count <= fill;
          end else begin
            scan <= scan + 1'b1;
            if (!scan_final) begin
              fill <= fill + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: latched command, slot table, result register
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.entry;
    end
    result <= result_next;
    if (state == krla_pkg::B_START && !full) begin
      if (cur.inward && found) begin
        slot_inward[found_idx] <= 1'b1;
        slot_colour[found_idx] <= cur.colour;
      end else begin
        slot_key[new_idx]    <= cur.key;
        slot_frame[new_idx]  <= cur.inward ? krla_pkg::LAST_FRAME : krla_pkg::FIRST_FRAME;
        slot_inward[new_idx] <= cur.inward;
        slot_colour[new_idx] <= cur.colour;
      end
    end
    if (state == krla_pkg::B_COMPACT && scan != active_count && !scan_final) begin
      slot_frame[fill_idx]  <= slot_inward[scan_idx] ? slot_frame[scan_idx] - 1'b1
                                                     : slot_frame[scan_idx] + 1'b1;
      slot_key[fill_idx]    <= slot_key[scan_idx];
      slot_inward[fill_idx] <= slot_inward[scan_idx];
      slot_colour[fill_idx] <= slot_colour[scan_idx];
    end
  end

endmodule
